[rtl/hcbd_pkg.sv]
// Package for the HTTP chunked body decoder.
// Holds the parse phase codes, status codes, the result type and the byte
// classification helpers. Depends on nothing.
package hcbd_pkg;

    localparam int SIZE_BITS_DEF = 32;

    localparam int PHASE_W = 3;
    localparam int STATUS_W = 2;

    localparam logic [PHASE_W-1:0] PH_SKIP = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SIZE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LF   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd3;
    localparam logic [PHASE_W-1:0] PH_END  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_EFMT = 3'd5;
    localparam logic [PHASE_W-1:0] PH_EOVF = 3'd6;

    localparam logic [STATUS_W-1:0] ST_BUSY = 2'd0;
    localparam logic [STATUS_W-1:0] ST_END  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EFMT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EOVF = 2'd3;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef struct packed {
        logic [7:0]          payload_byte;
        logic                payload_valid;
        logic                chunk_last;
        logic [STATUS_W-1:0] decode_status;
    } t_result;

    // Space, TAB, LF, VT, FF and CR.
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    // Bit 4 flags a hex digit; bits 3:0 carry its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c inside {["0":"9"]}) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {["a":"f"]}) begin
            v = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {["A":"F"]}) begin
            v = {1'b1, 4'(c - 8'h37)};
        end
        return v;
    endfunction

endpackage

[rtl/http_chunked_body_decoder_core.sv]
// HTTP chunked body decoder, top level: parse state, result register and
// the two valid/stall channels. Depends on hcbd_pkg and hcbd_step.
//
// The block takes one body byte per beat, starting right after the HTTP
// headers, and gives one result beat per input beat, in order. Whitespace
// before each chunk header is skipped, the hex size is collected, CR LF
// must follow, and then exactly that many bytes leave with payload_valid
// set, the last one of each chunk marked with chunk_last. A zero-size
// chunk ends the body at its LF (status 1). Extensions, signs, a 0x prefix
// or a missing LF give status 2, and a size that does not fit in
// SIZE_BITS bits gives status 3; end and errors hold until reset, and no
// payload is passed after them. Each result beat is registered and shows
// up in the cycle after its byte is accepted, and one byte is accepted
// every cycle unless the input stalls: the phase and count update for a
// byte is a single combinational step. The input side stalls only while
// a result beat is held and the output side stalls.
module http_chunked_body_decoder_core #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input channel
    input  logic                          i_in_valid,
    input  logic [7:0]                    i_data_byte,
    output logic                          o_in_stall,
    // Output channel
    output logic                          o_out_valid,
    output logic [7:0]                    o_payload_byte,
    output logic                          o_payload_valid,
    output logic                          o_chunk_last,
    output logic [hcbd_pkg::STATUS_W-1:0] o_decode_status,
    input  logic                          i_out_stall
);

    logic [hcbd_pkg::PHASE_W-1:0] r_phase;
    logic [hcbd_pkg::PHASE_W-1:0] n_phase;
    logic [SIZE_BITS-1:0]         r_count;
    logic [SIZE_BITS-1:0]         n_count;
    hcbd_pkg::t_result            r_result;
    hcbd_pkg::t_result            n_result;
    logic                         r_out_valid;
    logic                         in_accept;

    // The result register frees up in the same cycle it is taken.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    hcbd_step #(
        .SIZE_BITS(SIZE_BITS)
    ) u_step (
        .i_phase    (r_phase),
        .i_count    (r_count),
        .i_data_byte(i_data_byte),
        .o_phase    (n_phase),
        .o_count    (n_count),
        .o_result   (n_result)
    );

    // Parse state advances only on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hcbd_pkg::PH_SKIP;
            r_count <= '0;
        end else if (in_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // The payload register needs no reset; it loads with each accepted beat.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_byte  = r_result.payload_byte;
    assign o_payload_valid = r_result.payload_valid;
    assign o_chunk_last    = r_result.chunk_last;
    assign o_decode_status = r_result.decode_status;

    // A chunk being passed through always has bytes still due.
    a_data_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hcbd_pkg::PH_DATA) |-> (r_count != '0))
        else $error("data phase with zero bytes due");

    // The end of the body is sticky.
    a_end_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hcbd_pkg::PH_END) |=> (r_phase == hcbd_pkg::PH_END))
        else $error("left the end phase");

    // A chunk end marker only comes with payload, and payload only while busy.
    a_last_has_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_chunk_last) |->
            (o_payload_valid && o_decode_status == hcbd_pkg::ST_BUSY))
        else $error("chunk_last without payload");

    // An accepted beat always shows up at the output on the next edge.
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted beat lost");

endmodule

[rtl/hcbd_step.sv]
// Per-byte decode step of the HTTP chunked body decoder: next phase, next
// chunk count and the result for one body byte.
// Depends on hcbd_pkg.
module hcbd_step #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic [hcbd_pkg::PHASE_W-1:0] i_phase,
    input  logic [SIZE_BITS-1:0]         i_count,
    input  logic [7:0]                   i_data_byte,
    output logic [hcbd_pkg::PHASE_W-1:0] o_phase,
    output logic [SIZE_BITS-1:0]         o_count,
    output hcbd_pkg::t_result            o_result
);

    logic [4:0]           hex;
    logic [SIZE_BITS-1:0] count_dec;
    logic                 valid;
    logic                 last;

    assign hex       = hcbd_pkg::hex_value(i_data_byte);
    assign count_dec = i_count - SIZE_BITS'(1);

    always_comb begin
        o_phase = i_phase;
        o_count = i_count;
        valid   = 1'b0;
        last    = 1'b0;
        case (i_phase)
            hcbd_pkg::PH_SKIP: begin
                if (hcbd_pkg::is_space(i_data_byte)) begin
                    o_phase = i_phase;
                end else if (hex[4]) begin
                    o_count = SIZE_BITS'(hex[3:0]);
                    o_phase = hcbd_pkg::PH_SIZE;
                end else begin
                    o_phase = hcbd_pkg::PH_EFMT;
                end
            end
            hcbd_pkg::PH_SIZE: begin
                if (hex[4]) begin
                    // Another digit only fits while the top nibble is clear.
                    if (i_count[SIZE_BITS-1 -: 4] != 4'd0) begin
                        o_phase = hcbd_pkg::PH_EOVF;
                    end else begin
                        o_count = {i_count[SIZE_BITS-5:0], hex[3:0]};
                    end
                end else if (i_data_byte == hcbd_pkg::CHAR_CR) begin
                    o_phase = hcbd_pkg::PH_LF;
                end else begin
                    o_phase = hcbd_pkg::PH_EFMT;
                end
            end
            hcbd_pkg::PH_LF: begin
                if (i_data_byte == hcbd_pkg::CHAR_LF) begin
                    o_phase = (i_count == '0) ? hcbd_pkg::PH_END : hcbd_pkg::PH_DATA;
                end else begin
                    o_phase = hcbd_pkg::PH_EFMT;
                end
            end
            hcbd_pkg::PH_DATA: begin
                valid   = 1'b1;
                o_count = count_dec;
                if (count_dec == '0) begin
                    last    = 1'b1;
                    o_phase = hcbd_pkg::PH_SKIP;
                end
            end
            hcbd_pkg::PH_END, hcbd_pkg::PH_EOVF, hcbd_pkg::PH_EFMT: begin
                o_phase = i_phase;
            end
            default: begin
                o_phase = hcbd_pkg::PH_EFMT;
            end
        endcase
    end

    always_comb begin
        o_result.payload_byte  = valid ? i_data_byte : 8'd0;
        o_result.payload_valid = valid;
        o_result.chunk_last    = last;
        case (o_phase)
            hcbd_pkg::PH_END:  o_result.decode_status = hcbd_pkg::ST_END;
            hcbd_pkg::PH_EFMT: o_result.decode_status = hcbd_pkg::ST_EFMT;
            hcbd_pkg::PH_EOVF: o_result.decode_status = hcbd_pkg::ST_EOVF;
            default:           o_result.decode_status = hcbd_pkg::ST_BUSY;
        endcase
    end

endmodule

[dv/hcbd_tb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard class for the chunked body decoder testbench: a byte-level
// decode tracker that predicts each result beat and checks it against the
// block. Depends on hcbd_pkg for the phase and status codes and the result type.
package hcbd_tb_pkg;

    import hcbd_pkg::*;

    localparam int SIZE_W = SIZE_BITS_DEF;

    class chunk_decode_tracker;

        logic [PHASE_W-1:0] parse_state;
        logic [SIZE_W-1:0]  remaining;
        t_result            due_results[$];
        int                 mismatches;
        int                 beats_checked;
        int                 chunks_seen;
        int                 payload_seen;

        function new();
            parse_state = PH_SKIP;
            remaining = '0;
            mismatches = 0;
            beats_checked = 0;
            chunks_seen = 0;
            payload_seen = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Advance the decode state by one accepted byte and queue the result
        // beat that the block owes for it.
        function void note_byte(input logic [7:0] c);
            logic       is_ws;
            logic       is_hex;
            logic [3:0] nib;
            t_result    r;
            is_ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
            is_hex = (c >= 8'h30 && c <= 8'h39)
                     || ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h66);
            nib = c[3:0] + (c[6] ? 4'd9 : 4'd0);
            r = '0;
            case (parse_state)
                PH_SKIP: begin
                    if (is_hex) begin
                        remaining = '0;
                        remaining[3:0] = nib;
                        parse_state = PH_SIZE;
                    end else if (!is_ws) begin
                        parse_state = PH_EFMT;
                    end
                end
                PH_SIZE: begin
                    if (is_hex) begin
                        if (remaining[SIZE_W-1 -: 4] != 4'd0) begin
                            parse_state = PH_EOVF;
                        end else begin
                            remaining = {remaining[SIZE_W-5:0], nib};
                        end
                    end else if (c == CHAR_CR) begin
                        parse_state = PH_LF;
                    end else begin
                        parse_state = PH_EFMT;
                    end
                end
                PH_LF: begin
                    if (c != CHAR_LF) begin
                        parse_state = PH_EFMT;
                    end else if (remaining == '0) begin
                        parse_state = PH_END;
                    end else begin
                        parse_state = PH_DATA;
                    end
                end
                PH_DATA: begin
                    r.payload_valid = 1'b1;
                    r.payload_byte = c;
                    remaining = remaining - 1'b1;
                    if (remaining == '0) begin
                        r.chunk_last = 1'b1;
                        parse_state = PH_SKIP;
                    end
                end
                PH_END, PH_EOVF: begin
                end
                default: begin
                    parse_state = PH_EFMT;
                end
            endcase
            case (parse_state)
                PH_END:  r.decode_status = ST_END;
                PH_EFMT: r.decode_status = ST_EFMT;
                PH_EOVF: r.decode_status = ST_EOVF;
                default: r.decode_status = ST_BUSY;
            endcase
            due_results.push_back(r);
        endfunction

        function void report(input string what, input t_result e, input t_result g);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on beat %0d (%s): expected byte %02h valid %0b last %0b status %0d, got byte %02h valid %0b last %0b status %0d",
                         beats_checked, what, e.payload_byte, e.payload_valid,
                         e.chunk_last, e.decode_status, g.payload_byte,
                         g.payload_valid, g.chunk_last, g.decode_status);
            end
        endfunction

        function void check_beat(input t_result got);
            t_result e;
            beats_checked++;
            if (due_results.size() == 0) begin
                report("no beat expected", '0, got);
                return;
            end
            e = due_results.pop_front();
            if (got.payload_byte != e.payload_byte) report("payload_byte", e, got);
            else if (got.payload_valid != e.payload_valid) report("payload_valid", e, got);
            else if (got.chunk_last != e.chunk_last) report("chunk_last", e, got);
            else if (got.decode_status != e.decode_status) report("decode_status", e, got);
            if (e.payload_valid) payload_seen++;
            if (e.chunk_last) chunks_seen++;
        endfunction

    endclass

endpackage

[dv/testbench.sv]
`timescale 1ns / 1ps
// Top of the chunked body decoder testbench: clock, reset, stimulus tasks
// and the result sink. Depends on hcbd_pkg, hcbd_tb_pkg and the core RTL.
module testbench;

    import hcbd_pkg::*;
    import hcbd_tb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 600;
    localparam int HOLD_CYCLES = 80;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ONE = 8'h31;
    localparam logic [7:0] CH_TWO = 8'h32;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_X = 8'h78;

    typedef enum int {
        TERM_BODY_END,
        TERM_BAD_START,
        TERM_EXTENSION,
        TERM_SPACE_AFTER,
        TERM_HEX_PREFIX,
        TERM_NO_LF,
        TERM_OVERFLOW
    } term_kind_e;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic [7:0]          i_data_byte;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [7:0]          o_payload_byte;
    logic                o_payload_valid;
    logic                o_chunk_last;
    logic [STATUS_W-1:0] o_decode_status;
    logic                i_out_stall = 1'b0;

    // Pacing knobs, in percent of cycles, plus the long receiver hold-off.
    int   src_idle_pct;
    int   sink_idle_pct;
    logic sink_hold;
    int   bytes_sent;
    int   cycles = 0;
    string term_text;

    chunk_decode_tracker tracker = new();

    http_chunked_body_decoder_core #(
        .SIZE_BITS(SIZE_W)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_data_byte(i_data_byte),
        .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid),
        .o_payload_byte(o_payload_byte),
        .o_payload_valid(o_payload_valid),
        .o_chunk_last(o_chunk_last),
        .o_decode_status(o_decode_status),
        .i_out_stall(i_out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result sink. A beat is taken at an edge where valid was high and our
    // stall was low; everything sampled here still holds its pre-edge value
    // because all drivers use nonblocking assignments.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_beat({o_payload_byte, o_payload_valid, o_chunk_last,
                                o_decode_status});
        end
        i_out_stall <= sink_hold || ($urandom_range(0, 99) < sink_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still due", cycles,
                     tracker.pending());
            $display("** http_chunked_body_decoder_core: FAILED **");
            $finish;
        end
    end

    // Long receiver hold-off during the unthrottled stretch. The sender keeps
    // offering bytes, so the block fills its result register and must stall
    // its input until the hold is released.
    initial begin : long_hold
        int n;
        sink_hold = 1'b0;
        wait (bytes_sent >= 460);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) begin
            @(posedge i_clk);
        end
        sink_hold <= 1'b0;
    end

    // Offer one beat and hold it until accepted. Idle cycles are inserted
    // before the beat; valid is only ever lowered in a step where it is not
    // also raised.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        tracker.note_byte(b);
        bytes_sent++;
    endtask

    // Sender pause: drop valid and wait until every owed beat has arrived.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_ws(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: send_byte(CH_SPACE);
                1: send_byte(CH_TAB);
                2: send_byte(CHAR_LF);
                3: send_byte(CH_VT);
                4: send_byte(CH_FF);
                default: send_byte(CHAR_CR);
            endcase
        end
    endtask

    // Hex size, most significant digit first; digits past the value's width
    // come out as leading zeros.
    task automatic send_size(input logic [63:0] value, input int ndig, input bit upper);
        int         i;
        logic [3:0] nib;
        for (i = ndig - 1; i >= 0; i--) begin
            nib = 4'(value >> (4 * i));
            if (nib < 4'd10) send_byte(CH_ZERO + nib);
            else if (upper) send_byte(CH_UPPER_A + nib - 4'd10);
            else send_byte(CH_LOWER_A + nib - 4'd10);
        end
    endtask

    // Payload is mostly uniform, with framing bytes mixed in so that the
    // block must not react to CR, LF or digits inside a chunk.
    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 9))
            0: return CHAR_CR;
            1: return CHAR_LF;
            2: return CH_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_chunk();
        int len;
        int ndig;
        int i;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
        ndig = (len < 16) ? 1 : 2;
        if ($urandom_range(0, 3) == 0) ndig += $urandom_range(1, 6);
        send_ws(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        send_size(len, ndig, $urandom_range(0, 1));
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        for (i = 0; i < len; i++) begin
            send_byte(pick_payload());
        end
    endtask

    // A random non-whitespace, non-hex byte: the start of a malformed header.
    function automatic logic [7:0] pick_junk();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_SPACE || (b >= CH_TAB && b <= CHAR_CR)
                   || (b >= CH_ZERO && b <= CH_ZERO + 8'd9)
                   || ((b | 8'h20) >= CH_LOWER_A && (b | 8'h20) <= CH_LOWER_A + 8'd5));
        return b;
    endfunction

    // The end of the body and every error are sticky until reset, and reset
    // happens only once, so each run closes with one of them picked at random.
    // A well-formed chunk header followed by a tail of arbitrary bytes then
    // shows that the status holds and no payload leaks out.
    task automatic send_stream_end();
        term_kind_e kind;
        int         i;
        kind = term_kind_e'($urandom_range(0, 6));
        send_ws($urandom_range(0, 2));
        case (kind)
            TERM_BODY_END: begin
                term_text = "a zero-size last chunk";
                send_size(0, $urandom_range(1, 3), 1'b0);
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            TERM_BAD_START: begin
                term_text = "a malformed chunk header start";
                send_byte(pick_junk());
            end
            TERM_EXTENSION: begin
                term_text = "a chunk extension";
                send_size($urandom_range(1, 4096), 4, $urandom_range(0, 1));
                send_byte(CH_SEMI);
            end
            TERM_SPACE_AFTER: begin
                term_text = "a space after the chunk size";
                send_size($urandom_range(1, 255), 2, 1'b1);
                send_byte(CH_SPACE);
            end
            TERM_HEX_PREFIX: begin
                term_text = "a 0x size prefix";
                send_byte(CH_ZERO);
                send_byte(CH_X);
            end
            TERM_NO_LF: begin
                term_text = "a CR without LF after a full-width size";
                for (i = 0; i < 8; i++) send_byte(CH_UPPER_F);
                send_byte(CHAR_CR);
                send_byte(CH_SPACE);
            end
            default: begin
                term_text = "a chunk size overflow";
                send_size($urandom_range(1, 15), 1, 1'b1);
                send_size({$urandom, $urandom}, 8, $urandom_range(0, 1));
            end
        endcase
        send_byte(CH_ONE);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        for (i = 0; i < 20; i++) begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        int stage;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_data_byte <= 8'h00;
        bytes_sent = 0;
        stage = 0;
        src_idle_pct = 18;
        sink_idle_pct = 46;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every whitespace code before the first header, a one-byte chunk
        // carrying 0xFF, then a size with more leading zeros than the counter
        // has digits and a chunk that carries 0x00 and a CR as payload.
        send_byte(CH_SPACE);
        send_byte(CH_TAB);
        send_byte(CHAR_LF);
        send_byte(CH_VT);
        send_byte(CH_FF);
        send_byte(CHAR_CR);
        send_byte(CH_ONE);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte(8'hFF);
        repeat (10) send_byte(CH_ZERO);
        send_byte(CH_TWO);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte(8'h00);
        send_byte(CHAR_CR);

        // Random well-formed chunks: receiver idles more than the sender
        // first, then the other way round, then both run flat out.
        while (bytes_sent < RANDOM_BYTES) begin
            if (stage == 0 && bytes_sent >= 200) begin
                wait_for_results();
                src_idle_pct = 46;
                sink_idle_pct = 18;
                stage = 1;
            end else if (stage == 1 && bytes_sent >= 400) begin
                wait_for_results();
                src_idle_pct = 0;
                sink_idle_pct = 0;
                stage = 2;
            end
            send_random_chunk();
        end

        send_stream_end();
        wait_for_results();
        repeat (4) @(posedge i_clk);

        $display("Covered %0d bytes in %0d beats: %0d chunks, %0d payload bytes, closed by %s.",
                 bytes_sent, tracker.beats_checked, tracker.chunks_seen,
                 tracker.payload_seen, term_text);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("** http_chunked_body_decoder_core: PASSED **");
        end else begin
            $display("%0d mismatches, %0d beats never arrived", tracker.mismatches,
                     tracker.pending());
            $display("** http_chunked_body_decoder_core: FAILED **");
        end
        $finish;
    end

endmodule
